FILE: rtl/olst_pkg.sv
// olst_pkg: shared types and constants for the ordered list store.
// Operation and status codes, cell control struct. No dependencies.
`default_nettype none

package olst_pkg;

  localparam int VAL_W   = 32;  // entry / key width
  localparam int POS_W   = 8;   // input position width
  localparam int OP_W    = 3;   // operation code width
  localparam int ST_W    = 3;   // status code width
  localparam int OCNT_W  = 5;   // width of found_position and entry_count fields

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_RM_FIRST  = 3'd3,
    OP_RM_LAST   = 3'd4,
    OP_RM_AT     = 3'd5,
    OP_FIND      = 3'd6,
    OP_READ      = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_REM  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  fill;  // value to insert, or head for rotate
    logic signed [VAL_W-1:0]  key;   // find key
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/ordered_list_store_core.sv
// ordered_list_store_core: bounded ordered list of signed 32-bit entries.
// Top level; instantiates a chain of olst_cell, uses olst_pkg.
`default_nettype none
//
// Usage:
//   Input stream s_*: one transfer is one command. s_tuser carries the
//   operation, s_tdata the value/key and the 1-based position.
//   Output stream m_*: one transfer per result; m_tlast marks the final
//   result of a command. Insert, remove and find give one result, read
//   out gives one per entry (or a single list-empty result).
//   Storage is a row of DEPTH cells; insert and remove shift the cells
//   in parallel, find compares all cells at once.
// Sequence:
//   A command is taken in S_IDLE and executed in S_EXEC once the output
//   slot is free. Read out of a non-empty list goes from S_EXEC to
//   S_READ, then rotates the chain one cell per cycle while the output
//   slot is free, after which the list is back in its original order.
//   Find priority-encodes a match vector registered at acceptance.
// Reset (rst, synchronous): list empty, no result pending. Cell contents
//   are not cleared; only cells below the count are ever read.
// Stall: the output register holds its result while m_tready is low;
//   execution waits for the output slot, a new command is taken only
//   when the previous one has issued all its results.

module ordered_list_store_core
  import olst_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  // input command
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // [31:0] data_value, [39:32] position
  input  wire  [2:0]  s_tuser,   // [2:0] operation
  // results
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,   // [2:0] status, [34:3] element_value,
                                 // [39:35] found_position, [44:40] entry_count,
                                 // [47:45] zero
  output logic        m_tlast    // last_result
);

  localparam int CW = $clog2(DEPTH + 1);            // count width
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // cell index width
  localparam int PW = POS_W + 1;                    // position compare width

  // one-hot sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state, state_next;

  // latched command
  op_t                     cmd_op;
  logic signed [VAL_W-1:0] cmd_value;
  logic [POS_W-1:0]        cmd_pos;
  logic [DEPTH-1:0]        match_vec;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_left, rd_left_next;

  // output register
  status_t                 o_status, o_status_next;
  logic signed [VAL_W-1:0] o_elem, o_elem_next;
  logic [OCNT_W-1:0]       o_fpos, o_fpos_next;
  logic [OCNT_W-1:0]       o_count, o_count_next;
  logic                    o_last, o_last_next;
  logic                    load;

  // cell chain
  cell_ctl_t               ctl;
  logic [IW-1:0]           sel_idx;
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]        cell_match;

  logic          accept;
  logic          out_free;
  logic          hit;
  logic [CW-1:0] hit_pos;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign pos_ext  = PW'(cmd_pos);
  assign cnt_ext  = PW'(count);

  // ---------------------------------------------------------------------
  // cell row
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] lv, rv;
    if (g == 0) begin : g_head
      assign lv = '0;
    end else begin : g_mid
      assign lv = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign rv = cell_val[g];
    end else begin : g_nxt
      assign rv = cell_val[g+1];
    end
    olst_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel_idx   (sel_idx),
      .left_val  (lv),
      .right_val (rv),
      .val       (cell_val[g]),
      .match     (cell_match[g])
    );
  end

  // first match, 1-based
  always_comb begin
    hit     = |match_vec;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_pos = CW'(i + 1);
    end
  end

  // ---------------------------------------------------------------------
  // command capture; match vector is taken against the key on acceptance
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op    <= op_t'(s_tuser[OP_W-1:0]);
      cmd_value <= s_tdata[VAL_W-1:0];
      cmd_pos   <= s_tdata[VAL_W +: POS_W];
      for (int i = 0; i < DEPTH; i++) begin
        match_vec[i] <= cell_match[i] && (CW'(i) < count);
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequencer and cell control
  // ---------------------------------------------------------------------
  always_comb begin
    state_next    = state;
    count_next    = count;
    rd_left_next  = rd_left;
    load          = 1'b0;
    o_status_next = ST_OK;
    o_elem_next   = '0;
    o_fpos_next   = '0;
    o_count_next  = '0;
    o_last_next   = 1'b1;
    ctl.op        = CELL_HOLD;
    ctl.fill      = cmd_value;
    ctl.key       = s_tdata[VAL_W-1:0];
    sel_idx       = '0;

    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end

      S_EXEC: begin
        if (cmd_op == OP_READ && count != '0) begin
          // walk the list in S_READ
          rd_left_next = count;
          state_next   = S_READ;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
          case (cmd_op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
              if (count == CW'(DEPTH)) begin
                o_status_next = ST_FULL;
              end else if (cmd_op == OP_INS_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext + PW'(1))) begin
                o_status_next = ST_BADPOS;
              end else begin
                ctl.op     = CELL_INS;
                count_next = count + CW'(1);
                case (cmd_op)
                  OP_INS_FIRST: sel_idx = '0;
                  OP_INS_LAST:  sel_idx = IW'(count);
                  default:      sel_idx = IW'(cmd_pos - POS_W'(1));
                endcase
              end
            end
            OP_RM_FIRST, OP_RM_LAST, OP_RM_AT: begin
              if (count == '0) begin
                o_status_next = ST_EMPTY;
              end else if (cmd_op == OP_RM_AT &&
                           (pos_ext == '0 || pos_ext > cnt_ext)) begin
                o_status_next = ST_BADPOS;
              end else begin
                ctl.op     = CELL_REM;
                count_next = count - CW'(1);
                case (cmd_op)
                  OP_RM_FIRST: sel_idx = '0;
                  OP_RM_LAST:  sel_idx = IW'(count - CW'(1));
                  default:     sel_idx = IW'(cmd_pos - POS_W'(1));
                endcase
              end
            end
            OP_FIND: begin
              o_status_next = hit ? ST_OK : ST_NOTFOUND;
              o_fpos_next   = OCNT_W'(hit_pos);
            end
            default: begin
              // read out of an empty list
              o_status_next = ST_EMPTY;
            end
          endcase
          o_count_next = OCNT_W'(count_next);
        end
      end

      S_READ: begin
        if (out_free) begin
          load          = 1'b1;
          o_elem_next   = cell_val[0];
          o_count_next  = OCNT_W'(count);
          o_last_next   = (rd_left == CW'(1));
          // head goes to the tail slot, list order is restored at the end
          ctl.op        = CELL_ROT;
          ctl.fill      = cell_val[0];
          sel_idx       = IW'(count - CW'(1));
          rd_left_next  = rd_left - CW'(1);
          if (rd_left == CW'(1)) state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_left  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_left <= rd_left_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_status <= o_status_next;
      o_elem   <= o_elem_next;
      o_fpos   <= o_fpos_next;
      o_count  <= o_count_next;
      o_last   <= o_last_next;
    end
  end

  assign m_tdata = {3'b000, o_count, o_fpos, o_elem, o_status};
  assign m_tlast = o_last;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond DEPTH");

  a_read_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rd_left != '0) && (rd_left <= count))
    else $error("read-out counter out of range");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (load && ctl.op == CELL_INS) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not bump the count");

  a_rd_result: assert property (@(posedge clk) disable iff (rst)
    (load && state == S_READ) |=> m_tvalid && (o_status == ST_OK))
    else $error("read-out result not presented");
`endif

endmodule

`default_nettype wire

FILE: rtl/olst_cell.sv
// olst_cell: one storage cell of the list chain.
// Shifts left/right or rotates with its neighbors; depends on olst_pkg.
`default_nettype none

module olst_cell
  import olst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  wire                                  clk,
  input  wire  cell_ctl_t                      ctl,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] sel_idx,
  input  wire  signed [VAL_W-1:0]              left_val,
  input  wire  signed [VAL_W-1:0]              right_val,
  output logic signed [VAL_W-1:0]              val,
  output logic                                 match
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic signed [VAL_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctl.op)
      CELL_INS: begin
        if (MY_IDX == sel_idx) begin
          val_next = ctl.fill;
        end else if (MY_IDX > sel_idx) begin
          val_next = left_val;
        end
      end
      CELL_REM: begin
        if (MY_IDX >= sel_idx) begin
          val_next = right_val;
        end
      end
      CELL_ROT: begin
        // tail slot takes the head, the rest move one toward the head
        if (MY_IDX == sel_idx) begin
          val_next = ctl.fill;
        end else begin
          val_next = right_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign match = (val == ctl.key);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench for ordered_list_store_core.
// Drives list commands over the input stream, predicts results with a list
// model or the directed table, and checks the output stream. Depends on olst_pkg.
module tb_top
  import olst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 16;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] elem;
    logic [OCNT_W-1:0]       fpos;
    logic [OCNT_W-1:0]       cnt;
    logic                    last;
  } list_result_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    int                      reps;
    bit                      typed;
    status_t                 st;
    logic [OCNT_W-1:0]       cnt;
  } dir_row_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [31:0] data_value, [39:32] position
  logic [2:0]  s_tuser = '0;   // [2:0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [2:0] status, [34:3] element_value,
                               // [39:35] found_position, [44:40] entry_count
  logic        m_tlast;        // last_result

  // predictor state: the list contents, first entry at index 0
  logic signed [VAL_W-1:0] list_vals[$];
  list_result_t            awaited_results[$];
  int                      mismatch_cnt = 0;
  int                      result_idx = 0;
  bit                      quiet = 1'b0;     // no idling on either side
  bit                      hold_req = 1'b0;  // ask the receiver for a long hold-off
  dir_row_t                dir_rows[25];

  ordered_list_store_core #(.DEPTH(LIST_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_result(input status_t st, input logic signed [VAL_W-1:0] elem,
                             input logic [OCNT_W-1:0] fpos, input logic last);
    list_result_t r;
    r.status = st;
    r.elem   = elem;
    r.fpos   = fpos;
    r.cnt    = OCNT_W'(list_vals.size());
    r.last   = last;
    awaited_results.push_back(r);
  endtask

  // Applies one command to the list and, when keep is set, queues its results.
  task automatic apply_list_op(input op_t op, input logic signed [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos, input bit keep);
    status_t           st;
    logic [OCNT_W-1:0] fpos;
    int                n;
    int                p;
    st   = ST_OK;
    fpos = '0;
    n    = list_vals.size();
    p    = int'(pos);
    case (op)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        // full is checked ahead of the position
        if (n >= LIST_DEPTH) st = ST_FULL;
        else if (op == OP_INS_FIRST) list_vals.push_front(val);
        else if (op == OP_INS_LAST) list_vals.push_back(val);
        else if (p < 1 || p > n + 1) st = ST_BADPOS;
        else list_vals.insert(p - 1, val);
      end
      OP_RM_FIRST, OP_RM_LAST, OP_RM_AT: begin
        // empty is checked ahead of the position
        if (n == 0) st = ST_EMPTY;
        else if (op == OP_RM_FIRST) void'(list_vals.pop_front());
        else if (op == OP_RM_LAST) void'(list_vals.pop_back());
        else if (p < 1 || p > n) st = ST_BADPOS;
        else list_vals.delete(p - 1);
      end
      OP_FIND: begin
        st = ST_NOTFOUND;
        for (int i = 0; i < n; i++) begin
          if (list_vals[i] == val) begin
            st   = ST_OK;
            fpos = OCNT_W'(i + 1);
            break;
          end
        end
      end
      default: begin
        if (!keep) return;
        if (n == 0) push_result(ST_EMPTY, '0, '0, 1'b1);
        for (int i = 0; i < n; i++) push_result(ST_OK, list_vals[i], '0, i == n - 1);
        return;
      end
    endcase
    if (keep) push_result(st, '0, fpos, 1'b1);
  endtask

  // Offers one command and waits for the transfer; the prediction is made
  // at the accepting edge.
  task automatic send_cmd(input op_t op, input logic signed [VAL_W-1:0] val,
                          input logic [POS_W-1:0] pos, input bit typed,
                          input status_t st, input logic [OCNT_W-1:0] cnt);
    int gap;
    list_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pos, val};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_list_op(op, val, pos, !typed);
    if (typed) begin
      r.status = st;
      r.elem   = '0;
      r.fpos   = '0;
      r.cnt    = cnt;
      r.last   = 1'b1;
      awaited_results.push_back(r);
    end
    @(negedge clk);
  endtask

  function automatic op_t pick_op(input op_mix_t mix);
    op_t ins_ops[3];
    op_t rm_ops[3];
    int  r;
    int  ins_pct;
    int  rm_pct;
    ins_ops = '{OP_INS_FIRST, OP_INS_LAST, OP_INS_AT};
    rm_ops  = '{OP_RM_FIRST, OP_RM_LAST, OP_RM_AT};
    ins_pct = (mix == MIX_GROW) ? 65 : (mix == MIX_SHRINK) ? 15 : 35;
    rm_pct  = (mix == MIX_SHRINK) ? 65 : (mix == MIX_GROW) ? 15 : 35;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return ins_ops[$urandom_range(0, 2)];
    if (r < ins_pct + rm_pct) return rm_ops[$urandom_range(0, 2)];
    return ($urandom_range(0, 3) == 0) ? OP_READ : OP_FIND;
  endfunction

  // keys drawn from the list hit find matches; small values make duplicates
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && list_vals.size() > 0) return list_vals[$urandom_range(0, list_vals.size() - 1)];
    if (r < 55) return VAL_W'($signed($urandom_range(0, 6)) - 3);
    return $urandom;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 100)
      $display("ERROR t=%0t result %0d %s: got %0h, expected %0h",
               $realtime, result_idx, field, got, want);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = 150;
          hold_req   = 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    list_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata[31:0], 32'h0);
      end else begin
        w = awaited_results.pop_front();
        if (m_tdata[2:0] != w.status) report_mismatch("status", m_tdata[2:0], w.status);
        if (m_tdata[34:3] != w.elem) report_mismatch("element_value", m_tdata[34:3], w.elem);
        if (m_tdata[39:35] != w.fpos)
          report_mismatch("found_position", m_tdata[39:35], w.fpos);
        if (m_tdata[44:40] != w.cnt) report_mismatch("entry_count", m_tdata[44:40], w.cnt);
        if (m_tdata[47:45] != 3'b000) report_mismatch("pad bits", m_tdata[47:45], 32'h0);
        if (m_tlast != w.last) report_mismatch("last_result", m_tlast, w.last);
      end
      result_idx++;
    end
  end

  initial begin
    int      sent;
    int      phase_len;
    op_mix_t mix;
    op_t     op;
    logic [POS_W-1:0] pos;

    // directed table: empty-list codes, bad positions, extremes, fill to
    // full, full rejects, duplicate find, remove at the range edges
    dir_rows = '{
      '{OP_READ,      32'sh0,        8'd0,   1, 1'b1, ST_EMPTY,    5'd0},
      '{OP_RM_FIRST,  32'sh0,        8'd0,   1, 1'b1, ST_EMPTY,    5'd0},
      '{OP_RM_AT,     32'sh0,        8'd0,   1, 1'b1, ST_EMPTY,    5'd0},
      '{OP_FIND,      32'sh0,        8'd0,   1, 1'b1, ST_NOTFOUND, 5'd0},
      '{OP_INS_AT,    32'sh7,        8'd0,   1, 1'b1, ST_BADPOS,   5'd0},
      '{OP_INS_AT,    32'sh7,        8'd2,   1, 1'b1, ST_BADPOS,   5'd0},
      '{OP_INS_AT,    32'sh80000000, 8'd1,   1, 1'b1, ST_OK,       5'd1},
      '{OP_INS_LAST,  32'sh7FFFFFFF, 8'd0,   1, 1'b1, ST_OK,       5'd2},
      '{OP_INS_FIRST, 32'shFFFFFFFF, 8'd0,   1, 1'b1, ST_OK,       5'd3},
      '{OP_INS_AT,    32'sh0,        8'd4,   1, 1'b1, ST_OK,       5'd4},
      '{OP_INS_AT,    32'sh1,        8'd255, 1, 1'b1, ST_BADPOS,   5'd4},
      '{OP_READ,      32'sh0,        8'd0,   1, 1'b0, ST_OK,       5'd0},
      '{OP_INS_LAST,  32'sh5A5A5A5A, 8'd0,  11, 1'b0, ST_OK,       5'd0},
      '{OP_INS_AT,    32'sh5A5A5A5A, 8'd16,  1, 1'b1, ST_OK,       5'd16},
      '{OP_INS_AT,    32'sh3,        8'd0,   1, 1'b1, ST_FULL,     5'd16},
      '{OP_INS_FIRST, 32'sh3,        8'd0,   1, 1'b1, ST_FULL,     5'd16},
      '{OP_FIND,      32'sh5A5A5A5A, 8'd0,   1, 1'b0, ST_OK,       5'd0},
      '{OP_FIND,      32'sh12345678, 8'd0,   1, 1'b1, ST_NOTFOUND, 5'd16},
      '{OP_READ,      32'sh0,        8'd0,   1, 1'b0, ST_OK,       5'd0},
      '{OP_RM_AT,     32'sh0,        8'd17,  1, 1'b1, ST_BADPOS,   5'd16},
      '{OP_RM_AT,     32'sh0,        8'd0,   1, 1'b1, ST_BADPOS,   5'd16},
      '{OP_RM_AT,     32'sh0,        8'd16,  1, 1'b1, ST_OK,       5'd15},
      '{OP_RM_LAST,   32'sh0,        8'd0,   1, 1'b1, ST_OK,       5'd14},
      '{OP_RM_FIRST,  32'sh0,        8'd0,   1, 1'b1, ST_OK,       5'd13},
      '{OP_FIND,      32'sh80000000, 8'd0,   1, 1'b0, ST_OK,       5'd0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++)
        send_cmd(dir_rows[i].op, dir_rows[i].val, dir_rows[i].pos,
                 dir_rows[i].typed, dir_rows[i].st, dir_rows[i].cnt);
    end

    // random phases that push the list toward full or empty and back
    sent = 0;
    for (int ph = 0; sent < 135; ph++) begin
      mix       = op_mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(10, 30);
      quiet     = ($urandom_range(0, 3) == 0);
      if (ph == 2) begin
        // receiver holds off while the sender keeps offering
        quiet    = 1'b1;
        hold_req = 1'b1;
      end
      for (int k = 0; k < phase_len; k++) begin
        op = pick_op(mix);
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 255));
        else pos = POS_W'($urandom_range(0, list_vals.size() + 1));
        send_cmd(op, pick_value(), pos, 1'b0, ST_OK, '0);
        sent++;
      end
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: ordered_list_store_core.f
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/ordered_list_store_core.sv
tb/sv/tb_top.sv
